>>> sv/pse_pkg.sv
package pse_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int STEP_W      = $clog2(DATA_W);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_POPL = 6'b000010,
        S_LOAD = 6'b000100,
        S_CALC = 6'b001000,
        S_PUSH = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    function automatic status_t note_error(input status_t cur, input status_t code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    function automatic logic is_operator(input logic [7:0] ch);
        return (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH);
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

endpackage

>>> sv/postfix_stack_evaluator_top.sv
// Postfix expression evaluator.
// Input channel (in_valid/in_ready, char_code): one ASCII character per
// transaction. A digit pushes 0..9 onto a 128-entry stack of 32-bit values;
// + - * / pop right then left and push the 32-bit signed result; ')' pops
// the final value and sends it with the first error of the expression on the
// output channel (out_valid/out_ready, result_value, status), then clears the
// stack and the error. Any other character is dropped.
// Sequencing: a digit or an ignored character leaves the control in S_IDLE, so
// the next transaction is taken in the following cycle. An operator runs S_POPL,
// S_LOAD, S_CALC and S_PUSH: two stack reads through the registered memory port,
// a load step, a pass of the bit-serial adder, shift-add multiplier or restoring
// divider, and a push. A ')' waits in S_EMIT until the output register is free;
// its result appears on the output in the cycle after it leaves S_EMIT.
// A stalled receiver holds the result in the output register; further digits
// and operators are still accepted, and only the next ')' waits for the slot.
// Reset clears the stack count, the error, the control state and out_valid;
// the stack memory itself is not cleared and needs no clearing pass.
module postfix_stack_evaluator_top
    import pse_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               char_code,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] result_value,
    output logic [1:0]               status
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    status_t             err_reg, err_next;
    op_t                 op_reg, op_next;
    logic                pop_zero_reg, pop_zero_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;

    logic [DATA_W-1:0]   a_reg, a_next;
    logic [DATA_W-1:0]   b_reg, b_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic                carry_reg, carry_next;
    logic                neg_reg, neg_next;
    logic                dz_reg, dz_next;
    logic [DATA_W-1:0]   out_value_reg, out_value_next;
    status_t             out_status_reg, out_status_next;

    logic [DATA_W-1:0]   mem [STACK_DEPTH];
    logic [DATA_W-1:0]   mem_rd_reg;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [DATA_W-1:0]   wr_data;

    logic                stack_empty;
    logic                stack_full;
    logic [DATA_W-1:0]   pop_val;
    logic [DATA_W-1:0]   push_val;
    logic                sum_bit;
    logic [DATA_W:0]     rem_shift;
    logic [DATA_W:0]     rem_diff;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign status       = out_status_reg;

    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign rd_addr     = PTR_W'(count_reg - 1'b1);
    assign wr_addr     = count_reg[PTR_W-1:0];
    assign pop_val     = pop_zero_reg ? '0 : mem_rd_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        op_next         = op_reg;
        pop_zero_next   = pop_zero_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        carry_next      = carry_reg;
        neg_next        = neg_reg;
        dz_next         = dz_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_data         = '0;
        push_val        = '0;
        sum_bit         = 1'b0;
        rem_shift       = '0;
        rem_diff        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (is_digit(char_code))
                    begin
                        if (stack_full)
                        begin
                            err_next = note_error(err_reg, ST_OVERFLOW);
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_data    = DATA_W'(char_code - CH_ZERO);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (is_operator(char_code) || (char_code == CH_CLOSE))
                    begin
                        pop_zero_next = stack_empty;
                        if (stack_empty)
                        begin
                            err_next = note_error(err_reg, ST_UNDERFLOW);
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                        if (char_code == CH_CLOSE)
                        begin
                            count_next = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            unique case (char_code)
                                CH_PLUS:  op_next = OP_ADD;
                                CH_MINUS: op_next = OP_SUB;
                                CH_STAR:  op_next = OP_MUL;
                                default:  op_next = OP_DIV;
                            endcase
                            state_next = S_POPL;
                        end
                    end
                end
            end

            S_POPL:
            begin
                b_next        = pop_val;
                pop_zero_next = stack_empty;
                if (stack_empty)
                begin
                    err_next = note_error(err_reg, ST_UNDERFLOW);
                end
                else
                begin
                    rd_en      = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                step_next  = '0;
                acc_next   = '0;
                carry_next = (op_reg == OP_SUB);
                a_next     = pop_val;
                case (op_reg)
                    OP_SUB:
                    begin
                        b_next = ~b_reg;
                    end
                    OP_DIV:
                    begin
                        a_next   = pop_val[DATA_W-1] ? (~pop_val + 1'b1) : pop_val;
                        b_next   = b_reg[DATA_W-1] ? (~b_reg + 1'b1) : b_reg;
                        neg_next = pop_val[DATA_W-1] ^ b_reg[DATA_W-1];
                        dz_next  = (b_reg == '0);
                        if (b_reg == '0)
                        begin
                            err_next = note_error(err_reg, ST_DIVZERO);
                        end
                    end
                    default:
                    begin
                        b_next = b_reg;
                    end
                endcase
                state_next = S_CALC;
            end

            S_CALC:
            begin
                case (op_reg) inside
                    OP_ADD, OP_SUB:
                    begin
                        sum_bit    = a_reg[0] ^ b_reg[0] ^ carry_reg;
                        carry_next = (a_reg[0] & b_reg[0]) | (carry_reg & (a_reg[0] ^ b_reg[0]));
                        acc_next   = {sum_bit, acc_reg[DATA_W-1:1]};
                        a_next     = {1'b0, a_reg[DATA_W-1:1]};
                        b_next     = {1'b0, b_reg[DATA_W-1:1]};
                    end
                    OP_MUL:
                    begin
                        if (b_reg[0])
                        begin
                            acc_next = acc_reg + a_reg;
                        end
                        a_next = {a_reg[DATA_W-2:0], 1'b0};
                        b_next = {1'b0, b_reg[DATA_W-1:1]};
                    end
                    default:
                    begin
                        rem_shift = {acc_reg, a_reg[DATA_W-1]};
                        rem_diff  = rem_shift - {1'b0, b_reg};
                        if (!rem_diff[DATA_W])
                        begin
                            acc_next = rem_diff[DATA_W-1:0];
                            a_next   = {a_reg[DATA_W-2:0], 1'b1};
                        end
                        else
                        begin
                            acc_next = rem_shift[DATA_W-1:0];
                            a_next   = {a_reg[DATA_W-2:0], 1'b0};
                        end
                    end
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DATA_W - 1))
                begin
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                if (op_reg == OP_DIV)
                begin
                    push_val = dz_reg ? '0 : (neg_reg ? (~a_reg + 1'b1) : a_reg);
                end
                else
                begin
                    push_val = acc_reg;
                end
                if (stack_full)
                begin
                    err_next = note_error(err_reg, ST_OVERFLOW);
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = push_val;
                    count_next = count_reg + 1'b1;
                end
                state_next = S_IDLE;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = pop_val;
                    out_status_next = err_reg;
                    err_next        = ST_OK;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            op_reg        <= OP_ADD;
            pop_zero_reg  <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            op_reg        <= op_next;
            pop_zero_reg  <= pop_zero_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        acc_reg        <= acc_next;
        carry_reg      <= carry_next;
        neg_reg        <= neg_next;
        dz_reg         <= dz_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

endmodule

>>> sv/pse_checker.sv
module pse_checker
    import pse_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [7:0]               char_code,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] result_value,
    input logic [1:0]               status
);

    logic in_take;

    assign in_take = in_valid && in_ready;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
        else $error("stalled result changed or dropped");

    // reopen the input in the cycle after a digit or ignored character
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take && !is_operator(char_code) && (char_code != CH_CLOSE) |=> in_ready)
        else $error("single-cycle transaction blocked the input");

    // hold the input closed through S_POPL and S_LOAD after an operator is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take && is_operator(char_code) |=> !in_ready ##1 !in_ready)
        else $error("input reopened during operator evaluation");

    // emit the end-marker result through S_EMIT when the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take && (char_code == CH_CLOSE) && !out_valid |-> ##2 out_valid)
        else $error("end-marker result missing");

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .status       (status)
);
